### src/proff_pkg.sv
// Shared types and constants for the per-part range offset builder.
// Depends on nothing; the files that use it refer to it by scoped names.
`default_nettype none

package proff_pkg;

    localparam int unsigned PART_W  = 6;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned IDX_W   = 32;
    localparam int unsigned SIZE_W  = 31;
    localparam int unsigned ERR_W   = 2;
    localparam int unsigned S_DATA_W = 72;
    localparam int unsigned M_DATA_W = 80;

    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};
    localparam logic [CNT_W-1:0]  PART_LIMIT_RST = 7'd64;

    localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_PART = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NEG_LEN  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_SAT      = 2'd3;

    localparam logic KIND_RANGE = 1'b0;
    localparam logic KIND_SIZE  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted input beat
        logic prep;      // derive length and error of the held range
        logic item_wb;   // write back the sum and load the range result
        logic fin_sel;   // address the store with the finish counter
        logic fin_emit;  // load one part size result and advance
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // output register may be loaded this cycle
        logic fin_last;  // finish counter is on the last part in use
    } status_t;

endpackage

`default_nettype wire

### src/proff_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
`default_nettype none

module proff_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/proff_ctrl.sv
// Controller state machine: sequences range items and the finish sweep.
// Depends on proff_pkg (cmd_t, status_t).
`default_nettype none

module proff_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    input  wire logic               s_mode,
    output logic                    s_tready,
    input  wire proff_pkg::status_t sts,
    output proff_pkg::cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_ITEM_RD  = 3'd1;
    localparam logic [2:0] ST_ITEM_WB  = 3'd2;
    localparam logic [2:0] ST_FIN_RD   = 3'd3;
    localparam logic [2:0] ST_FIN_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = s_mode ? ST_FIN_RD : ST_ITEM_RD;
                end
            end
            ST_ITEM_RD: begin
                cmd.prep   = 1'b1;
                state_next = ST_ITEM_WB;
            end
            ST_ITEM_WB: begin
                // hold until the output register frees up
                if (sts.out_free) begin
                    cmd.item_wb = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_FIN_RD: begin
                cmd.fin_sel = 1'b1;
                state_next  = ST_FIN_EMIT;
            end
            ST_FIN_EMIT: begin
                cmd.fin_sel = 1'b1;
                if (sts.out_free) begin
                    cmd.fin_emit = 1'b1;
                    state_next   = sts.fin_last ? ST_IDLE : ST_FIN_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_range_to_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.capture && !s_mode) |=> (state_reg == ST_ITEM_RD))
        else $error("range beat did not move to the read step");
    a_read_to_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ITEM_RD) |=> (state_reg == ST_ITEM_WB))
        else $error("read step not followed by write-back");
    a_fin_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fin_emit && sts.fin_last) |=> (state_reg == ST_IDLE && s_tready))
        else $error("finish sweep did not return to idle");
`endif

endmodule

`default_nettype wire

### src/proff_dp.sv
// Datapath: item registers, per-part accumulator store with valid bits,
// finish counter and the output register. Depends on proff_pkg, proff_ram.
`default_nettype none

module proff_dp #(
    parameter int unsigned MAX_PARTS = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic [proff_pkg::CNT_W-1:0]      cfg_data,
    input  wire logic [proff_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire proff_pkg::cmd_t                  cmd,
    output proff_pkg::status_t                    sts,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [proff_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                  m_tuser,
    output logic                                  m_tlast
);

    localparam int unsigned AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam logic [proff_pkg::CNT_W-1:0] MAX_N = proff_pkg::CNT_W'(MAX_PARTS);

    // configuration
    logic [proff_pkg::CNT_W-1:0] part_limit_reg;
    logic [proff_pkg::CNT_W-1:0] n_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_limit_reg <= proff_pkg::PART_LIMIT_RST;
        end else if (cfg_valid) begin
            part_limit_reg <= cfg_data;
        end
    end

    always_comb begin
        n_eff = part_limit_reg;
        if (n_eff == '0) begin
            n_eff = proff_pkg::CNT_W'(1);
        end
        if (n_eff > MAX_N) begin
            n_eff = MAX_N;
        end
    end

    // held range item
    logic [proff_pkg::IDX_W-1:0]  begin_reg, end_reg, len_reg;
    logic [proff_pkg::PART_W-1:0] part_reg;
    logic                         bad_part_reg, neg_reg;
    logic                         part_ok;

    assign part_ok = ({1'b0, part_reg} < n_eff);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            begin_reg <= s_tdata[31:0];
            end_reg   <= s_tdata[63:32];
            part_reg  <= s_tdata[69:64];
        end
        if (cmd.prep) begin
            len_reg      <= end_reg - begin_reg;
            bad_part_reg <= !part_ok;
            neg_reg      <= (end_reg < begin_reg);
        end
    end

    // finish sweep counter and empty count
    logic [proff_pkg::PART_W-1:0] cnt_reg;
    logic [proff_pkg::CNT_W-1:0]  empty_reg;

    // store addressing: out-of-range parts read entry 0 and never write
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr_q;
    logic [proff_pkg::SIZE_W-1:0] ram_q;
    logic [proff_pkg::SIZE_W-1:0] cur_size;
    logic [MAX_PARTS-1:0] valid_reg;
    logic                 we;
    logic [proff_pkg::SIZE_W-1:0] wdata;

    assign wr_addr = part_ok ? part_reg[AW-1:0] : '0;
    assign rd_addr = cmd.fin_sel ? cnt_reg[AW-1:0] : wr_addr;

    always_ff @(posedge aclk) begin
        rd_addr_q <= rd_addr;
    end

    assign cur_size = valid_reg[rd_addr_q] ? ram_q : '0;

    proff_ram #(
        .WIDTH (proff_pkg::SIZE_W),
        .DEPTH (MAX_PARTS)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (wr_addr),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // range update
    logic [proff_pkg::IDX_W:0] sum;
    logic                      sat;
    logic                      upd;

    assign sum   = {2'b00, cur_size} + {1'b0, len_reg};
    assign sat   = (sum > {2'b00, proff_pkg::SIZE_MAX});
    assign upd   = !bad_part_reg && !neg_reg;
    assign we    = cmd.item_wb && upd;
    assign wdata = sat ? proff_pkg::SIZE_MAX : sum[proff_pkg::SIZE_W-1:0];

    logic fin_last;
    logic cur_empty;
    assign fin_last  = ({1'b0, cnt_reg} + proff_pkg::CNT_W'(1)) == n_eff;
    assign cur_empty = (cur_size == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.fin_emit && fin_last) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            empty_reg <= '0;
        end else if (cmd.capture) begin
            cnt_reg   <= '0;
            empty_reg <= '0;
        end else if (cmd.fin_emit) begin
            cnt_reg   <= cnt_reg + proff_pkg::PART_W'(1);
            empty_reg <= empty_reg + proff_pkg::CNT_W'(cur_empty);
        end
    end

    // output register
    logic                          out_valid_reg;
    logic                          kind_reg, last_reg;
    logic [proff_pkg::PART_W-1:0]  oidx_reg;
    logic [proff_pkg::SIZE_W-1:0]  ostart_reg, osize_reg;
    logic [proff_pkg::CNT_W-1:0]   oempty_reg;
    logic [proff_pkg::ERR_W-1:0]   oerr_reg;
    logic [proff_pkg::ERR_W-1:0]   item_err;

    assign sts.out_free = !out_valid_reg || m_tready;
    assign sts.fin_last = fin_last;

    always_comb begin
        if (bad_part_reg) begin
            item_err = proff_pkg::ERR_BAD_PART;
        end else if (neg_reg) begin
            item_err = proff_pkg::ERR_NEG_LEN;
        end else if (sat) begin
            item_err = proff_pkg::ERR_SAT;
        end else begin
            item_err = proff_pkg::ERR_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.item_wb || cmd.fin_emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_wb) begin
            kind_reg   <= proff_pkg::KIND_RANGE;
            oidx_reg   <= part_reg;
            ostart_reg <= upd ? cur_size : '0;
            osize_reg  <= '0;
            oempty_reg <= '0;
            oerr_reg   <= item_err;
            last_reg   <= 1'b1;
        end else if (cmd.fin_emit) begin
            kind_reg   <= proff_pkg::KIND_SIZE;
            oidx_reg   <= cnt_reg;
            ostart_reg <= '0;
            osize_reg  <= cur_size;
            oempty_reg <= fin_last ? (empty_reg + proff_pkg::CNT_W'(cur_empty)) : '0;
            oerr_reg   <= proff_pkg::ERR_OK;
            last_reg   <= fin_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {3'b000, oerr_reg, oempty_reg, osize_reg, ostart_reg, oidx_reg};

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.item_wb || cmd.fin_emit) |-> (!out_valid_reg || m_tready))
        else $error("output register loaded while a result still waits");
    a_clear_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.fin_emit && fin_last) |=> (valid_reg == '0))
        else $error("store not cleared after finish");
    a_size_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && kind_reg == proff_pkg::KIND_SIZE)
            |-> (oerr_reg == proff_pkg::ERR_OK && ostart_reg == '0))
        else $error("part size result carries range fields");
`endif

endmodule

`default_nettype wire

### src/per_part_range_offset_builder.sv
// Top level of the per-part range offset builder (segmented exclusive prefix sum).
// Depends on proff_pkg, proff_ctrl, proff_dp (which holds proff_ram).
//
//  Channel  Dir  Handshake            Payload
//  cfg      in   cfg_valid/cfg_ready  cfg_data: part limit
//  s        in   s_tvalid/s_tready    s_tdata: begin, end, part; s_tuser: mode
//  m        out  m_tvalid/m_tready    m_tdata: part, start, size, empty, error;
//                                     m_tuser: kind; m_tlast: last
//
// A range beat goes through accept, store read, then write-back with the output load.
// A finish beat is accepted, then each part in use gets a registered store read and an emit step.
// Reset (aresetn, synchronous, active low) clears every accumulator at once through its
// valid bit and sets the part limit to 64; there is no clearing sweep.
// A stalled m side holds the output register while the controller waits in its write-back
// or emit step; one more input beat is still taken, then s_tready stays low.
`default_nettype none

module per_part_range_offset_builder #(
    parameter int unsigned MAX_PARTS = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [proff_pkg::CNT_W-1:0]    cfg_data,    // [6:0] part limit
    // input beats
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [31:0] range_begin, [63:32] range_end, [69:64] part_id, [71:70] zero
    input  wire logic [proff_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                           s_tuser,     // [0] mode
    // result beats
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [5:0] part_index, [36:6] start_index, [67:37] part_size,
    // [74:68] empty_parts, [76:75] error, [79:77] zero
    output logic [proff_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                                m_tuser,     // [0] kind
    output logic                                m_tlast      // last
);

    proff_pkg::cmd_t    cmd;
    proff_pkg::status_t sts;

    // the user must write configuration only while idle; the block does not enforce it, so always take it
    assign cfg_ready = 1'b1;

    proff_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_mode   (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    proff_dp #(
        .MAX_PARTS (MAX_PARTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
